// ----- rtl/core/bmp24_to_rgb565_display_writer_defines.svh -----
// Assertion macros shared by the display writer RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef BMP24_TO_RGB565_DISPLAY_WRITER_DEFINES_SVH
`define BMP24_TO_RGB565_DISPLAY_WRITER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BMPDW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BMPDW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bmpdw_pkg.sv -----
// Shared types and constants of the BMP to RGB565 display writer.
// No dependencies.
package bmpdw_pkg;

    localparam int COORD_W = 10;   // panel coordinates
    localparam int ROWB_W  = 12;   // byte count within one stored row
    localparam int IMGW_W  = 11;   // image width once it passed the range check
    localparam int BMP_BPP = 24;
    localparam int BMP_MIN_PIXEL_OFFSET = 34;

    typedef enum logic [2:0] {
        KIND_CLEAR  = 3'd0,
        KIND_WINDOW = 3'd1,
        KIND_PIXEL  = 3'd2,
        KIND_REJECT = 3'd3,
        KIND_FINISH = 3'd4
    } kind_t;

    // Results caused by one file byte, in emission order: window, pixel, end.
    typedef struct packed {
        logic                 win_en;
        logic                 pix_en;
        logic                 end_en;
        kind_t                end_kind;
        logic [COORD_W-1:0]   x_start;
        logic [COORD_W-1:0]   x_end;
        logic [COORD_W-1:0]   row;
        logic [15:0]          pix;
    } bundle_t;

    // Placement of the image on the panel, derived from the header fields.
    typedef struct packed {
        logic [COORD_W-1:0]   x_first;
        logic [COORD_W-1:0]   x_last;
        logic [ROWB_W-1:0]    px;       // bytes drawn per row
        logic [ROWB_W-1:0]    rb_m1;    // stored row length minus one
        logic [COORD_W-1:0]   y_first;
        logic [COORD_W-1:0]   y_last;
        logic [31:0]          skip;     // stored rows below the panel
        logic                 bad;      // dimensions or offset out of range
    } geo_t;

endpackage

// ----- rtl/core/bmpdw_geometry.sv -----
// Registered image placement derived from the parsed header fields.
// Depends on bmpdw_pkg.
module bmpdw_geometry #(
    parameter int PANEL_WIDTH     = 240,
    parameter int PANEL_HEIGHT    = 320,
    parameter int MAX_IMAGE_WIDTH = 1280
) (
    input  logic                 clk,
    input  logic [31:0]          width,
    input  logic [31:0]          height,
    input  logic [31:0]          offset,
    output bmpdw_pkg::geo_t      geo
);

    bmpdw_pkg::geo_t geo_reg;
    bmpdw_pkg::geo_t geo_next;

    logic                                wide;
    logic                                tall;
    logic [bmpdw_pkg::IMGW_W-1:0]        w11;
    logic [bmpdw_pkg::COORD_W-1:0]       drawn;
    logic [bmpdw_pkg::COORD_W-1:0]       dx;
    logic [bmpdw_pkg::COORD_W-1:0]       dy;
    logic [bmpdw_pkg::IMGW_W+1:0]        w3;
    logic [bmpdw_pkg::IMGW_W+1:0]        rb;

    always_comb
    begin
        wide  = width > 32'(PANEL_WIDTH);
        tall  = height > 32'(PANEL_HEIGHT);
        w11   = width[bmpdw_pkg::IMGW_W-1:0];
        drawn = wide ? bmpdw_pkg::COORD_W'(PANEL_WIDTH) : width[bmpdw_pkg::COORD_W-1:0];
        dx    = bmpdw_pkg::COORD_W'(PANEL_WIDTH) - width[bmpdw_pkg::COORD_W-1:0];
        dy    = bmpdw_pkg::COORD_W'(PANEL_HEIGHT) - height[bmpdw_pkg::COORD_W-1:0];
        w3    = {2'b00, w11} + {1'b0, w11, 1'b0};
        rb    = (w3 + (bmpdw_pkg::IMGW_W+2)'(3)) & ~((bmpdw_pkg::IMGW_W+2)'(3));

        geo_next.x_first = wide ? '0 : {1'b0, dx[bmpdw_pkg::COORD_W-1:1]};
        geo_next.x_last  = geo_next.x_first + drawn - bmpdw_pkg::COORD_W'(1);
        geo_next.px      = {2'b00, drawn} + {1'b0, drawn, 1'b0};
        geo_next.rb_m1   = bmpdw_pkg::ROWB_W'(rb - (bmpdw_pkg::IMGW_W+2)'(1));
        geo_next.y_first = tall ? '0 : {1'b0, dy[bmpdw_pkg::COORD_W-1:1]};
        geo_next.y_last  = tall ? bmpdw_pkg::COORD_W'(PANEL_HEIGHT - 1)
                                : geo_next.y_first + height[bmpdw_pkg::COORD_W-1:0]
                                  - bmpdw_pkg::COORD_W'(1);
        geo_next.skip    = tall ? height - 32'(PANEL_HEIGHT) : 32'd0;
        geo_next.bad     = (width == 32'd0) || (width > 32'(MAX_IMAGE_WIDTH)) ||
                           (height == 32'd0) ||
                           (offset < 32'(bmpdw_pkg::BMP_MIN_PIXEL_OFFSET));
    end

    // Header fields settle well before the last header byte, so registering the placement is safe.
    always_ff @(posedge clk)
    begin
        geo_reg <= geo_next;
    end

    assign geo = geo_reg;

endmodule

// ----- rtl/core/bmpdw_parser.sv -----
// Byte-level BMP parser: header capture, row walk and pixel packing.
// Depends on bmpdw_pkg.
module bmpdw_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           file_byte,
    input  logic                 start_of_file,
    input  bmpdw_pkg::geo_t      geo,
    output logic [31:0]          width,
    output logic [31:0]          height,
    output logic [31:0]          offset,
    output bmpdw_pkg::bundle_t   bundle,
    output logic                 load
);

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_WAIT   = 5'b00100,
        PH_ROWS   = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    localparam logic [5:0] OFS_POS  = 6'd10;
    localparam logic [5:0] WID_POS  = 6'd18;
    localparam logic [5:0] HGT_POS  = 6'd22;
    localparam logic [5:0] PLN_POS  = 6'd26;
    localparam logic [5:0] BPP_POS  = 6'd28;
    localparam logic [5:0] CMP_POS  = 6'd30;
    localparam logic [5:0] HDR_LAST = 6'd33;

    phase_t                          phase_reg, phase_next, e_phase;
    logic [31:0]                     pos_reg, pos_next, e_pos;
    logic [31:0]                     offset_reg, offset_next, e_offset;
    logic [31:0]                     width_reg, width_next, e_width;
    logic [31:0]                     height_reg, height_next, e_height;
    logic [31:0]                     skip_reg, skip_next, e_skip;
    logic [2:0]                      flags_reg, flags_next, e_flags;
    logic [bmpdw_pkg::COORD_W-1:0]   row_reg, row_next, e_row;
    logic [bmpdw_pkg::ROWB_W-1:0]    bir_reg, bir_next, e_bir;
    logic [1:0]                      bit_reg, bit_next, e_bit;
    logic [10:0]                     pp_reg, pp_next, e_pp;
    logic [5:0]                      p;
    logic                            do_row;
    logic                            finished;

    always_comb
    begin
        // A start mark drops the current file and opens a header.
        if (start_of_file)
        begin
            e_phase  = PH_HEADER;
            e_pos    = '0;
            e_offset = '0;
            e_width  = '0;
            e_height = '0;
            e_skip   = '0;
            e_flags  = '0;
            e_row    = '0;
            e_bir    = '0;
            e_bit    = '0;
            e_pp     = '0;
        end
        else
        begin
            e_phase  = phase_reg;
            e_pos    = pos_reg;
            e_offset = offset_reg;
            e_width  = width_reg;
            e_height = height_reg;
            e_skip   = skip_reg;
            e_flags  = flags_reg;
            e_row    = row_reg;
            e_bir    = bir_reg;
            e_bit    = bit_reg;
            e_pp     = pp_reg;
        end

        phase_next  = e_phase;
        offset_next = e_offset;
        width_next  = e_width;
        height_next = e_height;
        skip_next   = e_skip;
        flags_next  = e_flags;
        row_next    = e_row;
        bir_next    = e_bir;
        bit_next    = e_bit;
        pp_next     = e_pp;
        bundle      = '0;
        do_row      = 1'b0;
        finished    = 1'b0;
        p           = e_pos[5:0];

        case (e_phase)
            PH_HEADER:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if (p == OFS_POS + 6'(k)) offset_next[8*k +: 8] = file_byte;
                    if (p == WID_POS + 6'(k)) width_next[8*k +: 8]  = file_byte;
                    if (p == HGT_POS + 6'(k)) height_next[8*k +: 8] = file_byte;
                end
                if ((p == PLN_POS && file_byte != 8'd1) ||
                    (p == PLN_POS + 6'd1 && file_byte != 8'd0))
                    flags_next[0] = 1'b1;
                if ((p == BPP_POS && file_byte != 8'(bmpdw_pkg::BMP_BPP)) ||
                    (p == BPP_POS + 6'd1 && file_byte != 8'd0))
                    flags_next[1] = 1'b1;
                if (p inside {[CMP_POS:HDR_LAST]} && file_byte != 8'd0)
                    flags_next[2] = 1'b1;
                if (p == HDR_LAST)
                begin
                    bundle.end_en = 1'b1;
                    if (flags_next != 3'd0 || geo.bad)
                    begin
                        bundle.end_kind = bmpdw_pkg::KIND_REJECT;
                        phase_next      = PH_DONE;
                    end
                    else
                    begin
                        bundle.end_kind = bmpdw_pkg::KIND_CLEAR;
                        skip_next       = geo.skip;
                        row_next        = geo.y_last;
                        bir_next        = '0;
                        bit_next        = '0;
                        pp_next         = '0;
                        phase_next      = PH_WAIT;
                    end
                end
            end
            PH_WAIT:
            begin
                if (e_pos == e_offset)
                begin
                    phase_next = PH_ROWS;
                    do_row     = 1'b1;
                end
            end
            PH_ROWS:
            begin
                do_row = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (do_row)
        begin
            if (e_skip == 32'd0)
            begin
                if (e_bir == '0)
                begin
                    bundle.win_en  = 1'b1;
                    bundle.x_start = geo.x_first;
                    bundle.x_end   = geo.x_last;
                    bundle.row     = e_row;
                end
                if (e_bir < geo.px)
                begin
                    case (e_bit)
                        2'd0:
                        begin
                            pp_next  = {6'd0, file_byte[7:3]};
                            bit_next = 2'd1;
                        end
                        2'd1:
                        begin
                            pp_next  = {file_byte[7:2], e_pp[4:0]};
                            bit_next = 2'd2;
                        end
                        default:
                        begin
                            bundle.pix_en = 1'b1;
                            bundle.pix    = {file_byte[7:3], e_pp};
                            bit_next      = 2'd0;
                            if (e_bir == geo.px - bmpdw_pkg::ROWB_W'(1) &&
                                e_row <= geo.y_first)
                            begin
                                bundle.end_en   = 1'b1;
                                bundle.end_kind = bmpdw_pkg::KIND_FINISH;
                                phase_next      = PH_DONE;
                                finished        = 1'b1;
                            end
                        end
                    endcase
                end
            end
            if (!finished)
            begin
                // Advance to the next stored row after its padding.
                if (e_bir >= geo.rb_m1)
                begin
                    bir_next = '0;
                    bit_next = '0;
                    if (e_skip != 32'd0) skip_next = e_skip - 32'd1;
                    else                 row_next  = e_row - bmpdw_pkg::COORD_W'(1);
                end
                else
                begin
                    bir_next = e_bir + bmpdw_pkg::ROWB_W'(1);
                end
            end
        end

        // Hold the position at all ones once it gets there.
        if (phase_next != PH_IDLE && e_pos != 32'hFFFF_FFFF) pos_next = e_pos + 32'd1;
        else                                                  pos_next = e_pos;

        load = accept && (bundle.win_en || bundle.pix_en || bundle.end_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            offset_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            skip_reg   <= '0;
            flags_reg  <= '0;
            row_reg    <= '0;
            bir_reg    <= '0;
            bit_reg    <= '0;
            pp_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            skip_reg   <= skip_next;
            flags_reg  <= flags_next;
            row_reg    <= row_next;
            bir_reg    <= bir_next;
            bit_reg    <= bit_next;
            pp_reg     <= pp_next;
        end
    end

    assign width  = width_reg;
    assign height = height_reg;
    assign offset = offset_reg;

endmodule

// ----- rtl/core/bmpdw_emitter.sv -----
// Two-deep result buffer that sends each byte's results one per transfer.
// Depends on bmpdw_pkg.
module bmpdw_emitter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  bmpdw_pkg::bundle_t   bundle,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           kind,
    output logic [9:0]           x_start,
    output logic [9:0]           x_end,
    output logic [9:0]           row,
    output logic [15:0]          pixel_rgb565,
    output logic                 last
);

    bmpdw_pkg::bundle_t  a_reg, a_next;
    bmpdw_pkg::bundle_t  b_reg, b_next;
    logic                a_any;
    logic                b_any;
    logic [1:0]          a_cnt;
    logic                xfer;
    logic                a_free;
    logic                sel_win;
    logic                sel_pix;

    assign a_any   = a_reg.win_en | a_reg.pix_en | a_reg.end_en;
    assign b_any   = b_reg.win_en | b_reg.pix_en | b_reg.end_en;
    assign a_cnt   = {1'b0, a_reg.win_en} + {1'b0, a_reg.pix_en} + {1'b0, a_reg.end_en};
    assign last    = (a_cnt == 2'd1);
    assign xfer    = a_any && out_ready;
    assign a_free  = !a_any || (xfer && last);
    assign sel_win = a_reg.win_en;
    assign sel_pix = !a_reg.win_en && a_reg.pix_en;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        // Drop the result just sent when more of the same byte remain.
        if (xfer && !last)
        begin
            if (a_reg.win_en) a_next.win_en = 1'b0;
            else              a_next.pix_en = 1'b0;
        end
        if (a_free)
        begin
            if (b_any)
            begin
                a_next        = b_reg;
                b_next.win_en = 1'b0;
                b_next.pix_en = 1'b0;
                b_next.end_en = 1'b0;
            end
            else if (load)
            begin
                a_next = bundle;
            end
            else
            begin
                a_next.win_en = 1'b0;
                a_next.pix_en = 1'b0;
                a_next.end_en = 1'b0;
            end
        end
        else if (load)
        begin
            b_next = bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign in_ready     = !b_any;
    assign out_valid    = a_any;
    assign kind         = sel_win ? bmpdw_pkg::KIND_WINDOW :
                          sel_pix ? bmpdw_pkg::KIND_PIXEL  : a_reg.end_kind;
    assign x_start      = sel_win ? a_reg.x_start : '0;
    assign x_end        = sel_win ? a_reg.x_end   : '0;
    assign row          = sel_win ? a_reg.row     : '0;
    assign pixel_rgb565 = sel_pix ? a_reg.pix     : '0;

endmodule

// ----- rtl/core/bmp24_to_rgb565_display_writer.sv -----
// Top level of the 24-bit BMP to RGB565 display writer.
// Depends on bmpdw_pkg, bmpdw_geometry, bmpdw_parser, bmpdw_emitter and the defines header.
//
// Feed a BMP file one byte per transfer on the input channel, with start_of_file
// high on its first byte. The block takes one byte every clock cycle while the
// result buffer has room; each byte is decoded in the cycle it is taken, and its
// results (none, one, two or three) are registered in the result buffer and sent
// on the output channel one result per transfer. The output channel therefore
// sets the sustained rate: a byte that yields k results occupies the output for
// k transfers, and a two-deep result buffer lets the input run one byte ahead of
// a stalled or busy output. Results come in this order: a clear (or reject) after
// header byte 33, then for each drawn panel row, bottom row first, a window
// command followed by that row's pixels, and a finish after the top row's last
// drawn pixel. Files with planes other than 1, depth other than 24, compression,
// zero or oversized width, zero height, or a pixel offset below 34 get a single
// reject. Fields that do not belong to a result kind read zero, and last marks
// the final result of each byte. Bytes outside an open file, padding, clipped
// pixels and rows below the panel give nothing.
`include "bmp24_to_rgb565_display_writer_defines.svh"

module bmp24_to_rgb565_display_writer #(
    parameter int PANEL_WIDTH     = 240,
    parameter int PANEL_HEIGHT    = 320,
    parameter int MAX_IMAGE_WIDTH = 1280
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   file_byte,
    input  logic         start_of_file,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [2:0]   kind,
    output logic [9:0]   x_start,
    output logic [9:0]   x_end,
    output logic [9:0]   row,
    output logic [15:0]  pixel_rgb565,
    output logic         last
);

    logic                 accept;
    logic                 load;
    logic [31:0]          width;
    logic [31:0]          height;
    logic [31:0]          offset;
    bmpdw_pkg::geo_t      geo;
    bmpdw_pkg::bundle_t   bundle;

    // One input transfer per cycle whenever the result buffer has room.
    assign accept = in_valid && in_ready;

    // Placement on the panel, re-derived every cycle from the header fields.
    bmpdw_geometry #(
        .PANEL_WIDTH     (PANEL_WIDTH),
        .PANEL_HEIGHT    (PANEL_HEIGHT),
        .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH)
    ) u_geometry (
        .clk    (clk),
        .width  (width),
        .height (height),
        .offset (offset),
        .geo    (geo)
    );

    // Parse header, walk rows bottom up, pack BGR into RGB565.
    bmpdw_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .file_byte     (file_byte),
        .start_of_file (start_of_file),
        .geo           (geo),
        .width         (width),
        .height        (height),
        .offset        (offset),
        .bundle        (bundle),
        .load          (load)
    );

    // Hold each byte's results and send them out in order.
    bmpdw_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .bundle       (bundle),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .x_start      (x_start),
        .x_end        (x_end),
        .row          (row),
        .pixel_rgb565 (pixel_rgb565),
        .last         (last)
    );

    // A full spare bundle means the output stage is busy.
    `BMPDW_ASSERT_NOW(a_stall_has_output, !in_ready, out_valid, "input stalled with no output pending")
    // A window never runs backward.
    `BMPDW_ASSERT_NOW(a_window_order, out_valid && kind == bmpdw_pkg::KIND_WINDOW, x_end >= x_start, "window end before start")
    // Window fields are zero on every other kind.
    `BMPDW_ASSERT_NOW(a_window_fields_zero, out_valid && kind != bmpdw_pkg::KIND_WINDOW, x_start == 10'd0 && x_end == 10'd0 && row == 10'd0, "window fields set outside a window")
    // More results of the same byte follow right after a non-final transfer.
    `BMPDW_ASSERT_NEXT(a_bundle_continues, out_valid && out_ready && !last, out_valid, "byte results cut short")

endmodule
